### rtl/assert_macros.svh
// assert_macros.svh: assertion macros used by the list store rtl
// no dependencies; taken in by `include where a module asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define CLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define CLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cls_pkg.sv
// cls_pkg: types and constants of the compacting list store
// used by cls_cell and compacting_list_store_core; no dependencies
package cls_pkg;

  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;
  localparam int unsigned POS_W             = 4;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned COUNT_W           = 5;
  localparam int unsigned WIDE_W            = 64;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_READ       = 3'd1,
    OP_WRITE      = 3'd2,
    OP_REMOVE_IDX = 3'd3,
    OP_REMOVE_VAL = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } state_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic capture;  // input beat taken: latch compare result
    logic commit;   // apply the pending command
    op_e  op;
  } cell_ctl_t;

endpackage

### rtl/cls_cell.sv
// cls_cell: one slot of the list, holds an entry and its match flag
// depends on cls_pkg; instantiated in a row by compacting_list_store_core
module cls_cell #(
  parameter int unsigned K     = 0,
  parameter int unsigned EW    = cls_pkg::ELEMENT_WIDTH_DEF,
  parameter int unsigned CMP_W = cls_pkg::COUNT_W
) (
  input  logic              clk_i,
  input  cls_pkg::cell_ctl_t ctl_i,
  input  logic [EW-1:0]     word_i,
  input  logic [CMP_W-1:0]  pos_i,
  input  logic [CMP_W-1:0]  count_i,
  input  logic [EW-1:0]     next_entry_i,
  input  logic              found_i,
  output logic              found_o,
  output logic [EW-1:0]     entry_o
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(K);

  logic [EW-1:0] entry_q, entry_d;
  logic          match_q;
  logic          in_list;
  logic          pos_ok;
  logic          hit;

  assign in_list = MY_IDX < count_i;
  assign pos_ok  = pos_i < count_i;
  assign hit     = match_q & in_list;
  // once this or a lower cell matched, this one and all above move down on a remove by value
  assign found_o = found_i | hit;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.commit) begin
      case (ctl_i.op)
        cls_pkg::OP_APPEND: begin
          if (MY_IDX == count_i) entry_d = word_i;
        end
        cls_pkg::OP_WRITE: begin
          if (pos_ok && MY_IDX == pos_i) entry_d = word_i;
        end
        cls_pkg::OP_REMOVE_IDX: begin
          if (pos_ok && MY_IDX >= pos_i) entry_d = next_entry_i;
        end
        cls_pkg::OP_REMOVE_VAL: begin
          if (found_o) entry_d = next_entry_i;
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctl_i.capture) begin
      match_q <= (entry_q == word_i);
    end
  end

endmodule

### rtl/compacting_list_store_core.sv
// compacting_list_store_core: ordered list store built as a row of cells
// depends on cls_pkg, cls_cell and assert_macros.svh
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i in_ready_o command_i position_i     | to block
//           | data_word_i                                    |
//   out     | out_valid_o out_ready_i status_o read_word_o   | from block
//           | entry_count_o                                  |
//
// every command has a beat edge and a commit edge: the beat edge latches the
// command while each cell registers its compare with the word, the commit edge
// applies the update in all cells at once and loads the result register.
// the commit edge waits while a previous result is not yet taken.
// reset clears count and control; entries hold garbage until written.
module compacting_list_store_core #(
  parameter int unsigned DEPTH         = cls_pkg::DEPTH_DEF,
  parameter int unsigned ELEMENT_WIDTH = cls_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   command_i,
  input  logic [cls_pkg::POS_W-1:0]    position_i,
  input  logic [cls_pkg::DATA_W-1:0]   data_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [cls_pkg::DATA_W-1:0]   read_word_o,
  output logic [cls_pkg::COUNT_W-1:0]  entry_count_o
);

  `include "assert_macros.svh"

  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > cls_pkg::POS_W) ? CNT_W : cls_pkg::POS_W;

  cls_pkg::state_e state_q, state_d;
  cls_pkg::op_e    cmd_q;
  logic [cls_pkg::POS_W-1:0] pos_q;
  logic [EW-1:0]   word_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic            out_valid_q;
  logic            status_q;
  logic [cls_pkg::DATA_W-1:0] read_q;

  logic            in_fire;
  logic            commit;
  logic            ok;
  logic [cls_pkg::DATA_W-1:0] rd_word;

  logic [cls_pkg::WIDE_W-1:0] data_ext;
  logic [cls_pkg::WIDE_W-1:0] rd_ext;
  logic [EW-1:0]   word_in;
  logic [EW-1:0]   word_bus;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic            in_range;

  cls_pkg::cell_ctl_t ctl;
  logic [EW-1:0]   entry [DEPTH];
  logic            found [DEPTH+1];

  // word cut or widened to the element width
  assign data_ext = cls_pkg::WIDE_W'(data_word_i);
  assign word_in  = data_ext[EW-1:0];
  assign word_bus = (state_q == cls_pkg::ST_IDLE) ? word_in : word_q;

  assign pos_c    = CMP_W'(pos_q);
  assign cnt_c    = CMP_W'(count_q);
  assign in_range = pos_c < cnt_c;

  assign in_fire = in_valid_i & in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cls_pkg::ST_IDLE:   if (in_fire) state_d = cls_pkg::ST_COMMIT;
      cls_pkg::ST_COMMIT: if (commit) state_d = cls_pkg::ST_IDLE;
      default:            state_d = cls_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      cls_pkg::ST_IDLE:   in_ready_o = 1'b1;
      cls_pkg::ST_COMMIT: commit = ~out_valid_q | out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  assign ctl.capture = in_fire;
  assign ctl.commit  = commit;
  assign ctl.op      = cmd_q;

  assign found[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EW-1:0] next_entry;
    if (g == DEPTH - 1) begin : g_last
      assign next_entry = entry[g];
    end else begin : g_mid
      assign next_entry = entry[g+1];
    end
    cls_cell #(
      .K     (g),
      .EW    (EW),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .word_i       (word_bus),
      .pos_i        (pos_c),
      .count_i      (cnt_c),
      .next_entry_i (next_entry),
      .found_i      (found[g]),
      .found_o      (found[g+1]),
      .entry_o      (entry[g])
    );
  end

  assign rd_ext = cls_pkg::WIDE_W'(entry[pos_c[IDX_W-1:0]]);

  // status, read data and new count of the pending command
  always_comb begin
    ok      = 1'b0;
    count_d = count_q;
    rd_word = '0;
    case (cmd_q)
      cls_pkg::OP_APPEND: begin
        ok = count_q < CNT_W'(DEPTH);
        if (ok) count_d = count_q + 1'b1;
      end
      cls_pkg::OP_READ: begin
        ok = in_range;
        if (ok) rd_word = rd_ext[cls_pkg::DATA_W-1:0];
      end
      cls_pkg::OP_WRITE: ok = in_range;
      cls_pkg::OP_REMOVE_IDX: begin
        ok = in_range;
        if (ok) count_d = count_q - 1'b1;
      end
      cls_pkg::OP_REMOVE_VAL: begin
        ok = found[DEPTH];
        if (ok) count_d = count_q - 1'b1;
      end
      cls_pkg::OP_CLEAR: begin
        ok      = 1'b1;
        count_d = '0;
      end
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cls_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cls_pkg::op_e'(command_i);
      pos_q  <= position_i;
      word_q <= word_in;
    end
    if (commit) begin
      status_q <= ~ok;
      read_q   <= rd_word;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_word_o   = read_q;
  // count only moves on a commit, together with the result register
  assign entry_count_o = cls_pkg::COUNT_W'(count_q);

  `CLS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "count past capacity")
  `CLS_ASSERT(a_beat_then_busy, clk_i, rst_ni, in_fire |=> !in_ready_o, "beat taken while busy")
  `CLS_ASSERT(a_remove_dec, clk_i, rst_ni,
    commit && ok && (cmd_q == cls_pkg::OP_REMOVE_IDX || cmd_q == cls_pkg::OP_REMOVE_VAL)
    |=> count_q == $past(count_q) - 1'b1, "remove did not shrink list")
  `CLS_ASSERT(a_fail_zero, clk_i, rst_ni, out_valid_o && status_o |-> read_word_o == '0,
    "failed command returned data")

endmodule
